// ===== rtl/csvp_pkg.sv =====
// ----------------------------------------------------------------------------
// csvp_pkg: shared types and constants of the quoted CSV line parser
// Holds the byte word that passes from the classifier to the parser, the
// event and error codes, and the default sizes.
// ----------------------------------------------------------------------------
package csvp_pkg;

    // Default record and field limits.
    localparam int FIELD_LIMIT_DEF = 16;
    localparam int FIELD_BYTES_DEF = 64;

    // Depth of the queue between classifier and parser (power of two).
    localparam int QUEUE_DEPTH = 4;

    // Character constants.
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Event kinds on the result channel.
    typedef enum logic [1:0] {
        EV_CHAR  = 2'd0,
        EV_FEND  = 2'd1,
        EV_REND  = 2'd2,
        EV_ERROR = 2'd3
    } event_kind_t;

    // Error codes.
    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_BAD_START = 3'd1,
        ERR_NL_FIELD  = 3'd2,
        ERR_TOO_LONG  = 3'd3,
        ERR_NO_COMMA  = 3'd4,
        ERR_NO_QUOTE  = 3'd5,
        ERR_TOO_MANY  = 3'd6
    } error_code_t;

    // One classified input word.
    typedef struct packed {
        logic [7:0] data;
        logic       is_nl;
        logic       is_blank;
        logic       is_quote;
        logic       is_comma;
        logic       is_hash;
    } csvp_item_t;

endpackage

// ===== rtl/quoted_csv_line_parser_core.sv =====
// ----------------------------------------------------------------------------
// quoted_csv_line_parser_core: streaming parser for quoted CSV lines
// Takes one text byte per word and emits field characters, field ends,
// record ends and error reports with the current line number.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall with data_byte. A byte is taken at a
//   rising edge with in_valid high and in_stall low. Output channel:
//   out_valid / out_stall with the result fields; a word is taken at a
//   rising edge with out_valid high and out_stall low.
//   Each byte yields zero or one result word. An accepted byte waits in
//   the queue; its result word is registered when the output is free.
//   Throughput is one byte per cycle while the receiver does not stall;
//   the parser state update runs from a four-word queue behind the classifier.
//   When the receiver stalls, the result register holds its word, the
//   parser stops, the queue fills, and in_stall rises once four bytes wait.
//   While a result word is stalled, no byte leaves the queue, even one that
//   gives no result.
//   Reset clears the queue and the result register and returns the parser
//   to the start of line one.
// ----------------------------------------------------------------------------
module quoted_csv_line_parser_core
#(
    parameter int FIELD_LIMIT = csvp_pkg::FIELD_LIMIT_DEF,
    parameter int FIELD_BYTES = csvp_pkg::FIELD_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  event_kind,
    output logic [7:0]  out_byte,
    output logic [3:0]  field_index,
    output logic [5:0]  char_index,
    output logic [4:0]  field_count,
    output logic [2:0]  error_code,
    output logic [15:0] line_number
);

    csvp_pkg::csvp_item_t push_item;
    csvp_pkg::csvp_item_t pop_item;
    logic                 q_full;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_valid;

    // Front: accept and classify.
    csvp_front u_front
    (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    // Queue between the two sides.
    csvp_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_item  (pop_item)
    );

    // Back: parse and deliver results.
    csvp_back
    #(
        .FIELD_LIMIT (FIELD_LIMIT),
        .FIELD_BYTES (FIELD_BYTES)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (pop_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_kind  (event_kind),
        .out_byte    (out_byte),
        .field_index (field_index),
        .char_index  (char_index),
        .field_count (field_count),
        .error_code  (error_code),
        .line_number (line_number)
    );

endmodule

// ===== rtl/csvp_front.sv =====
// ----------------------------------------------------------------------------
// csvp_front: input acceptance and byte classification
// Takes one byte word per cycle while the queue has room and tags it with
// the character classes that the parser needs.
// ----------------------------------------------------------------------------
module csvp_front
(
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           data_byte,
    input  logic                 q_full,
    output logic                 q_push,
    output csvp_pkg::csvp_item_t q_item
);

    // The input stalls only when the queue is full.
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // Classify the byte.
    always_comb
    begin
        q_item.data     = data_byte;
        q_item.is_nl    = (data_byte == csvp_pkg::CH_LF) || (data_byte == csvp_pkg::CH_NUL);
        q_item.is_blank = (data_byte == csvp_pkg::CH_SPACE) ||
                          ((data_byte >= csvp_pkg::CH_TAB) && (data_byte <= csvp_pkg::CH_CR));
        q_item.is_quote = (data_byte == csvp_pkg::CH_QUOTE);
        q_item.is_comma = (data_byte == csvp_pkg::CH_COMMA);
        q_item.is_hash  = (data_byte == csvp_pkg::CH_HASH);
    end

endmodule

// ===== rtl/csvp_queue.sv =====
// ----------------------------------------------------------------------------
// csvp_queue: short word queue between classifier and parser
// A small register queue so that the front and the back stall independently.
// ----------------------------------------------------------------------------
module csvp_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  csvp_pkg::csvp_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output csvp_pkg::csvp_item_t pop_item
);

    localparam int DEPTH = csvp_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW  = $clog2(DEPTH + 1);

    csvp_pkg::csvp_item_t mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign full      = (count_reg == CNTW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = mem_reg[rd_ptr_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && not_empty;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? PW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? PW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = CNTW'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = CNTW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/csvp_back.sv =====
// ----------------------------------------------------------------------------
// csvp_back: parser state machine and result register
// Consumes classified words, tracks the record, field and line state, and
// holds at most one result word in its output register.
// ----------------------------------------------------------------------------
module csvp_back
#(
    parameter int FIELD_LIMIT = csvp_pkg::FIELD_LIMIT_DEF,
    parameter int FIELD_BYTES = csvp_pkg::FIELD_BYTES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  csvp_pkg::csvp_item_t q_item,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           event_kind,
    output logic [7:0]           out_byte,
    output logic [3:0]           field_index,
    output logic [5:0]           char_index,
    output logic [4:0]           field_count,
    output logic [2:0]           error_code,
    output logic [15:0]          line_number
);

    localparam int FW = $clog2(FIELD_LIMIT + 1);
    localparam int CW = $clog2(FIELD_BYTES);

    typedef enum logic [2:0] {
        PH_LINE_START,
        PH_COMMENT,
        PH_IN_FIELD,
        PH_AFTER_CLOSE,
        PH_AFTER_COMMA,
        PH_DISCARD
    } phase_t;

    phase_t        phase_reg, phase_next;
    logic [FW-1:0] fields_reg, fields_next;
    logic [CW-1:0] chars_reg, chars_next;
    logic [15:0]   line_reg, line_next;

    logic          out_valid_reg, out_valid_next;
    logic [1:0]    kind_reg, kind_next;
    logic [7:0]    byte_reg, byte_next;
    logic [3:0]    fidx_reg, fidx_next;
    logic [5:0]    cidx_reg, cidx_next;
    logic [4:0]    fcnt_reg, fcnt_next;
    logic [2:0]    err_reg, err_next;
    logic [15:0]   lnum_reg, lnum_next;

    logic          go;
    logic          has_res;
    logic          inc_line;
    logic [31:0]   fields_wide;
    logic [31:0]   chars_wide;

    // A word is taken when the result register is free or being emptied.
    assign go    = q_valid && (!out_valid_reg || !out_stall);
    assign q_pop = go;

    assign fields_wide = 32'(fields_reg);
    assign chars_wide  = 32'(chars_reg);

    // Parser next state and result.
    always_comb
    begin
        phase_next  = phase_reg;
        fields_next = fields_reg;
        chars_next  = chars_reg;
        inc_line    = 1'b0;
        has_res     = 1'b0;
        kind_next   = csvp_pkg::EV_CHAR;
        byte_next   = '0;
        fidx_next   = '0;
        cidx_next   = '0;
        fcnt_next   = '0;
        err_next    = csvp_pkg::ERR_NONE;

        unique case (phase_reg)
            PH_LINE_START:
            begin
                priority if (q_item.is_nl)
                begin
                    inc_line = 1'b1;
                end
                else if (q_item.is_blank)
                begin
                    phase_next = PH_LINE_START;
                end
                else if (q_item.is_hash)
                begin
                    phase_next = PH_COMMENT;
                end
                else if (q_item.is_quote)
                begin
                    fields_next = '0;
                    chars_next  = '0;
                    phase_next  = PH_IN_FIELD;
                end
                else
                begin
                    has_res    = 1'b1;
                    kind_next  = csvp_pkg::EV_ERROR;
                    err_next   = csvp_pkg::ERR_BAD_START;
                    phase_next = PH_DISCARD;
                end
            end

            PH_IN_FIELD:
            begin
                priority if (q_item.is_quote)
                begin
                    has_res     = 1'b1;
                    kind_next   = csvp_pkg::EV_FEND;
                    fidx_next   = fields_wide[3:0];
                    cidx_next   = chars_wide[5:0];
                    fields_next = FW'(fields_reg + 1'b1);
                    phase_next  = PH_AFTER_CLOSE;
                end
                else if (q_item.is_nl)
                begin
                    has_res    = 1'b1;
                    kind_next  = csvp_pkg::EV_ERROR;
                    err_next   = csvp_pkg::ERR_NL_FIELD;
                    inc_line   = 1'b1;
                    phase_next = PH_LINE_START;
                end
                else if (chars_reg >= CW'(FIELD_BYTES - 1))
                begin
                    has_res    = 1'b1;
                    kind_next  = csvp_pkg::EV_ERROR;
                    err_next   = csvp_pkg::ERR_TOO_LONG;
                    phase_next = PH_DISCARD;
                end
                else
                begin
                    has_res    = 1'b1;
                    kind_next  = csvp_pkg::EV_CHAR;
                    byte_next  = q_item.data;
                    fidx_next  = fields_wide[3:0];
                    cidx_next  = chars_wide[5:0];
                    chars_next = CW'(chars_reg + 1'b1);
                end
            end

            PH_AFTER_CLOSE:
            begin
                priority if (q_item.is_nl)
                begin
                    has_res    = 1'b1;
                    kind_next  = csvp_pkg::EV_REND;
                    fcnt_next  = fields_wide[4:0];
                    inc_line   = 1'b1;
                    phase_next = PH_LINE_START;
                end
                else if (q_item.is_blank)
                begin
                    phase_next = PH_AFTER_CLOSE;
                end
                else if (q_item.is_comma)
                begin
                    phase_next = PH_AFTER_COMMA;
                end
                else
                begin
                    has_res    = 1'b1;
                    kind_next  = csvp_pkg::EV_ERROR;
                    err_next   = csvp_pkg::ERR_NO_COMMA;
                    phase_next = PH_DISCARD;
                end
            end

            PH_AFTER_COMMA:
            begin
                priority if (q_item.is_nl)
                begin
                    has_res    = 1'b1;
                    kind_next  = csvp_pkg::EV_ERROR;
                    err_next   = csvp_pkg::ERR_NO_QUOTE;
                    inc_line   = 1'b1;
                    phase_next = PH_LINE_START;
                end
                else if (q_item.is_blank)
                begin
                    phase_next = PH_AFTER_COMMA;
                end
                else if (q_item.is_quote)
                begin
                    if (fields_reg >= FW'(FIELD_LIMIT))
                    begin
                        has_res    = 1'b1;
                        kind_next  = csvp_pkg::EV_ERROR;
                        err_next   = csvp_pkg::ERR_TOO_MANY;
                        phase_next = PH_DISCARD;
                    end
                    else
                    begin
                        chars_next = '0;
                        phase_next = PH_IN_FIELD;
                    end
                end
                else
                begin
                    has_res    = 1'b1;
                    kind_next  = csvp_pkg::EV_ERROR;
                    err_next   = csvp_pkg::ERR_NO_QUOTE;
                    phase_next = PH_DISCARD;
                end
            end

            default:
            begin
                // Comment lines and lines after an error are dropped.
                if (q_item.is_nl)
                begin
                    inc_line   = 1'b1;
                    phase_next = PH_LINE_START;
                end
            end
        endcase

        // Every result carries the line number before any advance.
        lnum_next = line_reg;
        line_next = (inc_line && (line_reg != 16'hFFFF)) ? 16'(line_reg + 1'b1) : line_reg;

        if (go)
        begin
            out_valid_next = has_res;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    // Parser state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LINE_START;
            fields_reg    <= '0;
            chars_reg     <= '0;
            line_reg      <= 16'd1;
            out_valid_reg <= 1'b0;
            kind_reg      <= '0;
            byte_reg      <= '0;
            fidx_reg      <= '0;
            cidx_reg      <= '0;
            fcnt_reg      <= '0;
            err_reg       <= '0;
            lnum_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (go)
            begin
                phase_reg  <= phase_next;
                fields_reg <= fields_next;
                chars_reg  <= chars_next;
                line_reg   <= line_next;
                if (has_res)
                begin
                    kind_reg <= kind_next;
                    byte_reg <= byte_next;
                    fidx_reg <= fidx_next;
                    cidx_reg <= cidx_next;
                    fcnt_reg <= fcnt_next;
                    err_reg  <= err_next;
                    lnum_reg <= lnum_next;
                end
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_kind  = kind_reg;
    assign out_byte    = byte_reg;
    assign field_index = fidx_reg;
    assign char_index  = cidx_reg;
    assign field_count = fcnt_reg;
    assign error_code  = err_reg;
    assign line_number = lnum_reg;

endmodule
